### sv/lchc_pkg.sv
package lchc_pkg;

	localparam int ADDR_W  = 48;
	localparam int CAP_W   = 11;
	localparam int CNT_W   = 64;
	// use stamp; wide enough that it never wraps over the life of a part
	localparam int STAMP_W = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} lchc_state_t;

endpackage

### sv/lchc_ram.sv
module lchc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/lru_cache_hit_counter.sv
// Fully associative LRU cache model that counts read and write hits.
//
// Access channel: present block_address and is_read with start high; the
// access is taken at a rising edge where start is high and busy is low.
// busy stays high until the result is out. The result appears on hit,
// evicted_valid, evicted_address, read_hit_total and write_hit_total,
// marked by done, which is high for exactly one cycle; the receiver cannot stall it.
//
// Operation: an access sweeps the occupied entries of the entry memory
// through its single read port, one entry per cycle, waits for the read
// pipeline to drain, and then writes the entry back in the update state.
// A new access can be taken in the cycle done shows, but not before the
// previous access is through.
//
// Configuration: cfg_data is the capacity; cfg_ready is always high, write
// it only while busy is low. Capacity 0 acts as 1, above MAX_ENTRIES acts as
// MAX_ENTRIES.
//
// Reset: occupancy and both hit counters clear, capacity returns to 1024.
// The entry memory is not cleared; entries above occupancy are never used.
module lru_cache_hit_counter import lchc_pkg::*; #(
	parameter int MAX_ENTRIES  = 1024,
	parameter int ADDRESS_BITS = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [ADDR_W-1:0] block_address,
	input  logic              is_read,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data,
	output logic              done,
	output logic              hit,
	output logic              evicted_valid,
	output logic [ADDR_W-1:0] evicted_address,
	output logic [CNT_W-1:0]  read_hit_total,
	output logic [CNT_W-1:0]  write_hit_total
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
	localparam int ENT_W = ADDRESS_BITS + STAMP_W;

	lchc_state_t state_q, state_d;

	logic [CAP_W-1:0]        cap_q;
	logic [OCC_W-1:0]        eff_cap;
	logic [OCC_W-1:0]        occ_q;
	logic [OCC_W-1:0]        issue_q;
	logic                    issue;
	logic                    rd_v_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic                    is_read_q;
	logic                    found_q;
	logic [IDX_W-1:0]        hit_slot_q;
	logic [STAMP_W-1:0]      min_stamp_q;
	logic [IDX_W-1:0]        lru_slot_q;
	logic [ADDRESS_BITS-1:0] lru_tag_q;
	logic [STAMP_W-1:0]      now_q;
	logic [CNT_W-1:0]        rd_hits_q;
	logic [CNT_W-1:0]        wr_hits_q;

	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [ENT_W-1:0]        ram_rdata;
	logic [ADDRESS_BITS-1:0] ent_tag;
	logic [STAMP_W-1:0]      ent_stamp;
	logic                    evict;
	logic                    accept;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign issue     = (state_q == ST_SCAN) && (issue_q < occ_q);
	assign ent_tag   = ram_rdata[ENT_W-1:STAMP_W];
	assign ent_stamp = ram_rdata[STAMP_W-1:0];

	always_comb begin
		priority if (cap_q == '0) begin
			eff_cap = OCC_W'(1);
		end else if (32'(cap_q) > 32'(MAX_ENTRIES)) begin
			eff_cap = OCC_W'(MAX_ENTRIES);
		end else begin
			eff_cap = OCC_W'(cap_q);
		end
	end

	assign evict = !found_q && (occ_q >= eff_cap) && (occ_q != '0);

	always_comb begin
		priority if (found_q) begin
			ram_waddr = hit_slot_q;
		end else if (evict) begin
			ram_waddr = lru_slot_q;
		end else begin
			ram_waddr = occ_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		ram_we  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// leave once nothing is issued and nothing is in flight
				if (!issue && !rd_v_s1) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				ram_we  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	lchc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_ENTRIES)
	) u_ent_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({addr_q, now_q}),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_RESET;
			occ_q     <= '0;
			issue_q   <= '0;
			rd_v_s1   <= 1'b0;
			found_q   <= 1'b0;
			now_q     <= '0;
			rd_hits_q <= '0;
			wr_hits_q <= '0;
			done      <= 1'b0;
		end else begin
			done    <= (state_q == ST_UPDATE);
			rd_v_s1 <= issue;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (accept) begin
				issue_q <= '0;
				found_q <= 1'b0;
			end
			if (issue) begin
				issue_q <= issue_q + OCC_W'(1);
			end
			if (rd_v_s1 && !found_q && ent_tag == addr_q) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_UPDATE) begin
				now_q <= now_q + STAMP_W'(1);
				if (found_q) begin
					if (is_read_q && rd_hits_q != '1) begin
						rd_hits_q <= rd_hits_q + CNT_W'(1);
					end
					if (!is_read_q && wr_hits_q != '1) begin
						wr_hits_q <= wr_hits_q + CNT_W'(1);
					end
				end else if (!evict) begin
					occ_q <= occ_q + OCC_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q[IDX_W-1:0];
		if (accept) begin
			addr_q      <= ADDRESS_BITS'(block_address);
			is_read_q   <= is_read;
			min_stamp_q <= '1;
		end
		if (rd_v_s1) begin
			if (!found_q && ent_tag == addr_q) begin
				hit_slot_q <= rd_idx_s1;
			end
			// oldest stamp marks the LRU entry
			if (ent_stamp < min_stamp_q) begin
				min_stamp_q <= ent_stamp;
				lru_slot_q  <= rd_idx_s1;
				lru_tag_q   <= ent_tag;
			end
		end
		if (state_q == ST_UPDATE) begin
			hit             <= found_q;
			evicted_valid   <= evict;
			evicted_address <= evict ? ADDR_W'(lru_tag_q) : '0;
		end
	end

	assign read_hit_total  = rd_hits_q;
	assign write_hit_total = wr_hits_q;

endmodule

### sv/lchc_checker.sv
module lchc_checker import lchc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              hit,
	input logic              evicted_valid,
	input logic [ADDR_W-1:0] evicted_address,
	input logic [CNT_W-1:0]  read_hit_total,
	input logic [CNT_W-1:0]  write_hit_total
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted access");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done shown while still busy");

	a_no_evict_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && (hit || !evicted_valid) |-> !evicted_valid && evicted_address == '0)
		else $error("eviction reported on a hit or stray evicted address");

	a_miss_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> read_hit_total == $past(read_hit_total)
			&& write_hit_total == $past(write_hit_total))
		else $error("hit counter moved on a miss");

endmodule

bind lru_cache_hit_counter lchc_checker u_lchc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.hit             (hit),
	.evicted_valid   (evicted_valid),
	.evicted_address (evicted_address),
	.read_hit_total  (read_hit_total),
	.write_hit_total (write_hit_total)
);

### bench/lru_access_checker.sv
module lru_access_checker import lchc_pkg::*; #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [ADDR_W-1:0] block_address,
	input  logic              is_read,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data,
	input  logic              done,
	input  logic              hit,
	input  logic              evicted_valid,
	input  logic [ADDR_W-1:0] evicted_address,
	input  logic [CNT_W-1:0]  read_hit_total,
	input  logic [CNT_W-1:0]  write_hit_total,
	output int                mismatch_count,
	output int                results_owed
);

	typedef struct packed {
		logic              hit;
		logic              evicted_valid;
		logic [ADDR_W-1:0] evicted_address;
		logic [CNT_W-1:0]  read_total;
		logic [CNT_W-1:0]  write_total;
	} access_outcome_t;

	// front is most recently used, back is the next victim
	logic [ADDR_W-1:0] recency_q[$];
	logic [CAP_W-1:0]  capacity;
	logic [CNT_W-1:0]  read_hits;
	logic [CNT_W-1:0]  write_hits;
	access_outcome_t   outcome_q[$];
	int                errors = 0;

	assign mismatch_count = errors;

	task automatic flag_mismatch(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic access_outcome_t lru_access(input logic [ADDR_W-1:0] addr,
			input logic rd);
		access_outcome_t o;
		int found;
		int limit;
		o = '0;
		found = -1;
		foreach (recency_q[i]) begin
			if (found < 0 && recency_q[i] == addr)
				found = i;
		end
		if (capacity == 0)
			limit = 1;
		else if (capacity > MAX_ENTRIES)
			limit = MAX_ENTRIES;
		else
			limit = int'(capacity);
		if (found >= 0) begin
			o.hit = 1'b1;
			if (rd) begin
				if (read_hits != '1)
					read_hits++;
			end else begin
				if (write_hits != '1)
					write_hits++;
			end
			recency_q.delete(found);
			recency_q.insert(0, addr);
		end else begin
			// a lowered capacity drains one victim per miss, never more
			if (recency_q.size() >= limit) begin
				o.evicted_valid = 1'b1;
				o.evicted_address = recency_q[$];
				recency_q.delete(recency_q.size() - 1);
			end
			if (recency_q.size() < MAX_ENTRIES)
				recency_q.insert(0, addr);
		end
		o.read_total = read_hits;
		o.write_total = write_hits;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		access_outcome_t want;
		if (!arst_n) begin
			recency_q.delete();
			outcome_q.delete();
			capacity = CAP_RESET;
			read_hits = '0;
			write_hits = '0;
			results_owed <= 0;
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					flag_mismatch("result beat with no access outstanding");
				end else begin
					want = outcome_q.pop_front();
					if (hit !== want.hit)
						flag_mismatch($sformatf("hit %0b, expected %0b", hit, want.hit));
					if (evicted_valid !== want.evicted_valid)
						flag_mismatch($sformatf("evicted_valid %0b, expected %0b",
							evicted_valid, want.evicted_valid));
					if (evicted_address !== want.evicted_address)
						flag_mismatch($sformatf("evicted_address %h, expected %h",
							evicted_address, want.evicted_address));
					if (read_hit_total !== want.read_total)
						flag_mismatch($sformatf("read_hit_total %0d, expected %0d",
							read_hit_total, want.read_total));
					if (write_hit_total !== want.write_total)
						flag_mismatch($sformatf("write_hit_total %0d, expected %0d",
							write_hit_total, want.write_total));
				end
			end
			if (cfg_valid && cfg_ready)
				capacity = cfg_data;
			if (start && !busy)
				outcome_q.push_back(lru_access(block_address, is_read));
			results_owed <= outcome_q.size();
		end
	end

endmodule

### bench/tb_lru_cache_hit_counter.sv
module tb_lru_cache_hit_counter;
	import lchc_pkg::*;

	localparam int MAX_ENTRIES = 1024;
	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int POOL_SIZE   = 20;

	localparam logic [ADDR_W-1:0] ADDR_ZERO  = '0;
	localparam logic [ADDR_W-1:0] ADDR_ONES  = '1;
	localparam logic [ADDR_W-1:0] ADDR_ODD   = 48'h5555_5555_5555;
	localparam logic [ADDR_W-1:0] ADDR_EVEN  = 48'hAAAA_AAAA_AAAA;
	localparam logic [ADDR_W-1:0] ADDR_LSB   = 48'h0000_0000_0001;
	localparam logic [ADDR_W-1:0] ADDR_MSB   = 48'h8000_0000_0000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [ADDR_W-1:0] block_address = '0;
	logic              is_read = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_data = '0;
	logic              done;
	logic              hit;
	logic              evicted_valid;
	logic [ADDR_W-1:0] evicted_address;
	logic [CNT_W-1:0]  read_hit_total;
	logic [CNT_W-1:0]  write_hit_total;
	int                mismatch_count;
	int                results_owed;
	int                cycle_count = 0;
	int                idle_pct = 17;
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

	always #1 clk = ~clk;

	lru_cache_hit_counter #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.ADDRESS_BITS(ADDR_W)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.block_address  (block_address),
		.is_read        (is_read),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.hit            (hit),
		.evicted_valid  (evicted_valid),
		.evicted_address(evicted_address),
		.read_hit_total (read_hit_total),
		.write_hit_total(write_hit_total)
	);

	lru_access_checker #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) access_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.block_address  (block_address),
		.is_read        (is_read),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.done           (done),
		.hit            (hit),
		.evicted_valid  (evicted_valid),
		.evicted_address(evicted_address),
		.read_hit_total (read_hit_total),
		.write_hit_total(write_hit_total),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	task automatic issue_access(input logic [ADDR_W-1:0] addr, input logic rd);
		start <= 1'b1;
		block_address <= addr;
		is_read <= rd;
		@(posedge clk);
		while (busy) @(posedge clk);
		// hold start high for back-to-back beats unless the sender idles
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(12, 1)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (results_owed != 0 || busy) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ADDR_W-1:0] pick_address();
		if ($urandom_range(99) < 80)
			return addr_pool[$urandom_range(POOL_SIZE - 1)];
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	initial begin
		logic [ADDR_W-1:0] fill_base;
		foreach (addr_pool[i])
			addr_pool[i] = ADDR_W'({$urandom(), $urandom()});
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// zero capacity behaves as one entry
		write_capacity('0);
		issue_access(ADDR_ZERO, 1'b0);
		issue_access(ADDR_ZERO, 1'b1);
		issue_access(ADDR_ONES, 1'b1);
		issue_access(ADDR_ONES, 1'b0);
		issue_access(ADDR_ZERO, 1'b1);

		write_capacity(CAP_W'(1));
		issue_access(ADDR_ONES, 1'b1);
		issue_access(ADDR_ONES, 1'b1);

		write_capacity(CAP_W'(3));
		issue_access(ADDR_ODD, 1'b0);
		issue_access(ADDR_EVEN, 1'b1);
		issue_access(ADDR_ONES, 1'b0);
		issue_access(ADDR_ODD, 1'b1);
		issue_access(ADDR_ZERO, 1'b0);
		issue_access(ADDR_EVEN, 1'b1);

		// lower capacity below occupancy: each miss evicts one entry only
		write_capacity(CAP_W'(2));
		issue_access(ADDR_LSB, 1'b1);
		issue_access(ADDR_MSB, 1'b0);
		issue_access(ADDR_ODD, 1'b1);

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 17 : (phase == 1) ? 46 : 0;
			for (int half = 0; half < 2; half++) begin
				write_capacity(CAP_W'($urandom_range(12, 2)));
				for (int n = 0; n < 80; n++) begin
					if (n % 40 == 39)
						wait_drained();
					issue_access(pick_address(), 1'($urandom_range(1)));
				end
			end
		end

		// capacity above the entry count saturates
		write_capacity({CAP_W{1'b1}});
		fill_base = ADDR_W'({$urandom(), 16'h0000});
		for (int n = 0; n < 60; n++)
			issue_access(fill_base + ADDR_W'(n), 1'($urandom_range(1)));
		for (int n = 0; n < 12; n++)
			issue_access(fill_base + ADDR_W'($urandom_range(72)),
				1'($urandom_range(1)));

		write_capacity(CAP_W'(MAX_ENTRIES));
		for (int n = 0; n < 12; n++)
			issue_access(pick_address(), 1'($urandom_range(1)));

		wait_drained();
		repeat (MAX_ENTRIES + 8) @(posedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("lru_cache_hit_counter verification clean");
		else
			$display("lru_cache_hit_counter verification failed");
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lru_cache_hit_counter verification failed");
			$finish;
		end
	end

endmodule
